### rtl/core/nfci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfci_pkg: shared types and constants of the NOR flash command interface
// Holds the command bytes, identifier codes, the queued operation format and
// the state types used by the front and back parts.
// ----------------------------------------------------------------------------
package nfci_pkg;

  localparam int ARRAY_BYTES = 524288;
  localparam int ADDR_W      = 19;
  localparam int ARRAY_PAIRS = ARRAY_BYTES / 2;
  localparam int PAIR_W      = ADDR_W - 1;
  localparam int DATA_W      = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // access kinds
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // command bytes
  localparam logic [7:0] CMD_RESET        = 8'hF0;
  localparam logic [7:0] CMD_UNLOCK1      = 8'hAA;
  localparam logic [7:0] CMD_UNLOCK2      = 8'h55;
  localparam logic [7:0] CMD_AUTOSELECT   = 8'h90;
  localparam logic [7:0] CMD_FAST_EXIT    = 8'h90;
  localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
  localparam logic [7:0] CMD_ERASE_SETUP  = 8'h80;
  localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;
  localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
  localparam logic [7:0] CMD_FAST_ENTER   = 8'h20;

  localparam logic [11:0] UNLOCK1_OFFSET = 12'hAAA;
  localparam logic [11:0] UNLOCK2_OFFSET = 12'h555;

  localparam logic [11:0] ID_MFR_OFFSET = 12'h000;
  localparam logic [11:0] ID_DEV_OFFSET = 12'h001;
  localparam logic [DATA_W-1:0] MFR_CODE    = 16'h0004;
  localparam logic [DATA_W-1:0] DEVICE_CODE = 16'h220C;

  localparam logic [7:0] STATUS_DATA_MASK = 8'h80;
  localparam logic [7:0] STATUS_DONE      = 8'h04;
  localparam logic [7:0] ERASED_BYTE      = 8'hFF;

  // sector map boundaries (top boot)
  localparam logic [ADDR_W-1:0] SEC_BOOT_START  = 19'h60000;
  localparam logic [ADDR_W-1:0] SEC_MID32_START = 19'h64000;
  localparam logic [ADDR_W-1:0] SEC_PARAM_START = 19'h6C000;
  localparam logic [ADDR_W-1:0] SEC_HI32_START  = 19'h74000;
  localparam logic [ADDR_W-1:0] SEC_TOP16_START = 19'h7C000;
  localparam logic [ADDR_W-1:0] SIZE_64K        = 19'h10000;
  localparam logic [ADDR_W-1:0] SIZE_32K        = 19'h08000;
  localparam logic [ADDR_W-1:0] SIZE_16K        = 19'h04000;
  localparam logic [ADDR_W-1:0] SIZE_8K         = 19'h02000;

  typedef enum logic [1:0] {
    UNLOCK_IDLE   = 2'd0,
    UNLOCK_FIRST  = 2'd1,
    UNLOCK_SECOND = 2'd2
  } unlock_step_t;

  typedef enum logic [2:0] {
    OP_READ_BYTE,
    OP_READ_WORD,
    OP_READ_STATUS,
    OP_READ_CONST,
    OP_PROGRAM,
    OP_ERASE
  } op_code_t;

  // addr: byte address, or first pair (shifted up by one) for erase
  typedef struct packed {
    op_code_t          op_code;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic [PAIR_W-1:0] last_pair;
  } nfci_op_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_PROGRAM,
    BK_ERASE
  } back_state_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage
`default_nettype wire

### rtl/core/nfci_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfci_in_if: bus access channel
// Valid/ready channel carrying one read or write access per transfer.
// ----------------------------------------------------------------------------
interface nfci_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [18:0] address;
  logic        word_access;
  logic [7:0]  write_byte;

  modport source (output valid, command, address, word_access, write_byte, input ready);
  modport sink   (input valid, command, address, word_access, write_byte, output ready);
endinterface
`default_nettype wire

### rtl/core/nfci_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfci_out_if: read data channel
// Valid/ready channel carrying the data of one read access per transfer.
// ----------------------------------------------------------------------------
interface nfci_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface
`default_nettype wire

### rtl/core/nfci_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfci_front: access decoder and command state
// Tracks unlock, ID, fast, program and armed states and turns each read,
// program write and erase command into an array operation for the back part.
// ----------------------------------------------------------------------------
module nfci_front (
  input  wire                   clk,
  input  wire                   rst,
  nfci_in_if.sink               access,
  input  wire                   q_full,
  input  nfci_pkg::back_status_t status,
  output logic                  push,
  output nfci_pkg::nfci_op_t    push_op
);
  import nfci_pkg::*;

  unlock_step_t      unlock_step, unlock_step_next;
  logic              id_mode, id_mode_next;
  logic              program_pending, program_pending_next;
  logic              fast_mode, fast_mode_next;
  logic              erase_armed, erase_armed_next;

  logic              accept;
  logic              op_valid;
  logic [ADDR_W-1:0] a;
  logic [7:0]        b;
  logic [ADDR_W-1:0] id_addr;
  logic [ADDR_W-1:0] sec_base;
  logic [ADDR_W-1:0] sec_size;
  logic [PAIR_W-1:0] sec_first;
  logic [PAIR_W-1:0] sec_last;

  assign a            = access.address;
  assign b            = access.write_byte;
  assign access.ready = !q_full && !status.clearing;
  assign accept       = access.valid && access.ready;
  assign push         = accept && op_valid;

  // sector containing the address
  always_comb begin
    if (a < SEC_BOOT_START) begin
      sec_base = {a[18:16], 16'h0000};
      sec_size = SIZE_64K;
    end else if (a < SEC_MID32_START) begin
      sec_base = SEC_BOOT_START;
      sec_size = SIZE_16K;
    end else if (a < SEC_PARAM_START) begin
      sec_base = SEC_MID32_START;
      sec_size = SIZE_32K;
    end else if (a < SEC_HI32_START) begin
      sec_base = {a[18:13], 13'h0000};
      sec_size = SIZE_8K;
    end else if (a < SEC_TOP16_START) begin
      sec_base = SEC_HI32_START;
      sec_size = SIZE_32K;
    end else begin
      sec_base = SEC_TOP16_START;
      sec_size = SIZE_16K;
    end
    sec_first = sec_base[ADDR_W-1:1];
    sec_last  = PAIR_W'(sec_first + sec_size[ADDR_W-1:1] - PAIR_W'(1));
  end

  // next command state
  always_comb begin
    unlock_step_next     = unlock_step;
    id_mode_next         = id_mode;
    program_pending_next = program_pending;
    fast_mode_next       = fast_mode;
    erase_armed_next     = erase_armed;
    if (access.command == ACC_WRITE) begin
      if (program_pending) begin
        program_pending_next = 1'b0;
      end else if (fast_mode) begin
        if (b == CMD_PROGRAM)   program_pending_next = 1'b1;
        if (b == CMD_FAST_EXIT) fast_mode_next = 1'b0;
      end else begin
        unique case (unlock_step)
          UNLOCK_FIRST: begin
            unlock_step_next = (b == CMD_UNLOCK2 && a[11:0] == UNLOCK2_OFFSET) ?
                               UNLOCK_SECOND : UNLOCK_IDLE;
          end
          UNLOCK_SECOND: begin
            erase_armed_next = 1'b0;
            if (b == CMD_RESET)       id_mode_next = 1'b0;
            if (b == CMD_AUTOSELECT)  id_mode_next = 1'b1;
            if (b == CMD_PROGRAM)     program_pending_next = 1'b1;
            if (b == CMD_ERASE_SETUP) erase_armed_next = 1'b1;
            if (b == CMD_FAST_ENTER)  fast_mode_next = 1'b1;
            unlock_step_next = UNLOCK_IDLE;
          end
          default: begin
            unlock_step_next = UNLOCK_IDLE;
            if (b == CMD_RESET) id_mode_next = 1'b0;
            if (b == CMD_UNLOCK1 && a[11:0] == UNLOCK1_OFFSET) unlock_step_next = UNLOCK_FIRST;
          end
        endcase
      end
    end
  end

  // operation handed to the back part
  always_comb begin
    op_valid          = 1'b0;
    push_op.op_code   = OP_READ_CONST;
    push_op.addr      = a;
    push_op.value     = '0;
    push_op.last_pair = '0;
    id_addr           = access.word_access ? a : {1'b0, a[ADDR_W-1:1]};
    if (access.command == ACC_READ) begin
      op_valid = 1'b1;
      if (fast_mode) begin
        push_op.op_code = OP_READ_STATUS;
      end else if (id_mode) begin
        push_op.op_code = OP_READ_CONST;
        if (!access.word_access && a[0]) begin
          push_op.value = '0;
        end else if (id_addr[11:0] == ID_MFR_OFFSET) begin
          push_op.value = MFR_CODE;
        end else if (id_addr[11:0] == ID_DEV_OFFSET) begin
          push_op.value = DEVICE_CODE;
        end
      end else begin
        push_op.op_code = access.word_access ? OP_READ_WORD : OP_READ_BYTE;
      end
    end else if (program_pending) begin
      op_valid        = 1'b1;
      push_op.op_code = OP_PROGRAM;
      push_op.value   = {8'h00, b};
    end else if (!fast_mode && unlock_step == UNLOCK_SECOND && erase_armed) begin
      if (b == CMD_CHIP_ERASE) begin
        op_valid          = 1'b1;
        push_op.op_code   = OP_ERASE;
        push_op.addr      = '0;
        push_op.last_pair = '1;
      end else if (b == CMD_SECTOR_ERASE) begin
        op_valid          = 1'b1;
        push_op.op_code   = OP_ERASE;
        push_op.addr      = {sec_first, 1'b0};
        push_op.last_pair = sec_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_step     <= UNLOCK_IDLE;
      id_mode         <= 1'b0;
      program_pending <= 1'b0;
      fast_mode       <= 1'b0;
      erase_armed     <= 1'b0;
    end else if (accept) begin
      unlock_step     <= unlock_step_next;
      id_mode         <= id_mode_next;
      program_pending <= program_pending_next;
      fast_mode       <= fast_mode_next;
      erase_armed     <= erase_armed_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/nfci_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfci_queue: operation queue
// Short FIFO between decoder and array engine.
// ----------------------------------------------------------------------------
module nfci_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  nfci_pkg::nfci_op_t push_op,
  output logic               full,
  input  wire                pop,
  output nfci_pkg::nfci_op_t head,
  output logic               empty
);
  import nfci_pkg::*;

  nfci_op_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= QUEUE_PTR_W'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= QUEUE_PTR_W'(rd_ptr + 1'b1);
      if (push && !pop)      count <= QUEUE_CNT_W'(count + 1'b1);
      else if (pop && !push) count <= QUEUE_CNT_W'(count - 1'b1);
    end
  end

endmodule
`default_nettype wire

### rtl/core/nfci_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfci_back: array engine
// Holds the flash array as even and odd byte banks, runs reads, program
// read-modify-writes and erase sweeps, and drives the read data channel.
// ----------------------------------------------------------------------------
module nfci_back (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    q_empty,
  input  nfci_pkg::nfci_op_t     head,
  output logic                   pop,
  output nfci_pkg::back_status_t status,
  nfci_out_if.source             reply
);
  import nfci_pkg::*;

  logic [7:0]        even_mem [ARRAY_PAIRS];
  logic [7:0]        odd_mem  [ARRAY_PAIRS];
  logic [7:0]        even_q;
  logic [7:0]        odd_q;

  back_state_t       state, state_next;
  logic [PAIR_W-1:0] pair_idx;
  logic [PAIR_W-1:0] last_pair;
  op_code_t          cur_op;
  logic [ADDR_W-1:0] cur_addr;
  logic [7:0]        cur_byte;

  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  logic              out_free;
  logic              head_is_read;

  logic [PAIR_W-1:0] rd_idx;
  logic [PAIR_W-1:0] wr_idx;
  logic              even_we;
  logic              odd_we;
  logic [7:0]        wr_data;
  logic [7:0]        sel_byte;

  assign out_free        = !out_valid || reply.ready;
  assign status.clearing = (state == BK_CLEAR);
  assign reply.valid     = out_valid;
  assign reply.read_data = out_data;
  assign rd_idx          = (head.op_code == OP_READ_WORD) ? head.addr[PAIR_W-1:0]
                                                          : head.addr[ADDR_W-1:1];
  assign sel_byte        = cur_addr[0] ? odd_q : even_q;
  assign head_is_read    = (head.op_code == OP_READ_BYTE) || (head.op_code == OP_READ_WORD) ||
                           (head.op_code == OP_READ_STATUS) || (head.op_code == OP_READ_CONST);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR:   if (pair_idx == '1) state_next = BK_IDLE;
      BK_IDLE: begin
        if (pop) begin
          case (head.op_code)
            OP_READ_CONST: state_next = BK_IDLE;
            OP_PROGRAM:    state_next = BK_PROGRAM;
            OP_ERASE:      state_next = BK_ERASE;
            default:       state_next = BK_READ;
          endcase
        end
      end
      BK_READ:    state_next = BK_IDLE;
      BK_PROGRAM: state_next = BK_IDLE;
      BK_ERASE:   if (pair_idx == last_pair) state_next = BK_IDLE;
      default:    state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    even_we = 1'b0;
    odd_we  = 1'b0;
    wr_idx  = pair_idx;
    wr_data = ERASED_BYTE;
    unique case (state)
      BK_CLEAR, BK_ERASE: begin
        even_we = 1'b1;
        odd_we  = 1'b1;
      end
      BK_IDLE: begin
        // reads wait until the output register can take their data
        if (!q_empty) pop = head_is_read ? out_free : 1'b1;
      end
      BK_PROGRAM: begin
        wr_idx  = cur_addr[ADDR_W-1:1];
        wr_data = sel_byte & cur_byte;
        even_we = !cur_addr[0];
        odd_we  = cur_addr[0];
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    even_q <= even_mem[rd_idx];
    odd_q  <= odd_mem[rd_idx];
    if (even_we) even_mem[wr_idx] <= wr_data;
    if (odd_we)  odd_mem[wr_idx]  <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_op   <= head.op_code;
      cur_addr <= head.addr;
      cur_byte <= head.value[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      pair_idx  <= '0;
      last_pair <= '1;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR || state == BK_ERASE) begin
        pair_idx <= PAIR_W'(pair_idx + 1'b1);
      end else if (pop && head.op_code == OP_ERASE) begin
        pair_idx  <= head.addr[ADDR_W-1:1];
        last_pair <= head.last_pair;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BK_READ || (pop && head.op_code == OP_READ_CONST)) begin
      out_valid <= 1'b1;
    end else if (reply.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.op_code == OP_READ_CONST) begin
      out_data <= head.value;
    end else if (state == BK_READ) begin
      case (cur_op)
        OP_READ_WORD:   out_data <= {odd_q, even_q};
        OP_READ_STATUS: out_data <= {8'h00, (sel_byte & STATUS_DATA_MASK) | STATUS_DONE};
        default:        out_data <= {8'h00, sel_byte};
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/nor_flash_command_interface_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nor_flash_command_interface_top: 512 KB top-boot NOR flash command interface
// Bus-side model of a NOR flash with the standard unlock command set.
// ----------------------------------------------------------------------------
// Usage:
//   access : one bus access per transfer (command 0 read, 1 write). Writes
//            drive the command state; reads return array data, identifier
//            codes in ID mode, or program-complete status in fast mode.
//   reply  : one transfer per read access carrying read_data; writes give
//            nothing. Replies come back in access order.
// Operation flow:
//   A read goes through the queue, the registered array read in the read
//   state and the output register (an ID read skips the array read); the
//   engine takes no new read while one is in its read state. A program
//   reads the byte, then writes it ANDed with the new byte. An erase writes
//   one even/odd byte pair per cycle over the sector or the whole array.
// Reset:
//   Clears the command state and runs a pass that writes the whole array
//   to 0xFF; access.ready stays low until it ends.
// Stall:
//   A stalled reply holds its data; the two-entry queue between decoder
//   and array engine keeps taking accesses until it fills, then holds ready.
// ----------------------------------------------------------------------------
module nor_flash_command_interface_top (
  input  wire         clk,
  input  wire         rst,
  nfci_in_if.sink     access,
  nfci_out_if.source  reply
);
  import nfci_pkg::*;

  // decoder to queue
  logic         push;
  nfci_op_t     push_op;
  logic         q_full;

  // queue to array engine
  logic         pop;
  nfci_op_t     head;
  logic         q_empty;
  back_status_t status;

  // decode accesses and track unlock/mode state
  nfci_front u_front (
    .clk     (clk),
    .rst     (rst),
    .access  (access),
    .q_full  (q_full),
    .status  (status),
    .push    (push),
    .push_op (push_op)
  );

  // buffer operations so decode and array work stall independently
  nfci_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty)
  );

  // carry out reads, programs and erases on the array
  nfci_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .status  (status),
    .reply   (reply)
  );

endmodule
`default_nettype wire
